// ===== hw/rtl/lz10_pkg.sv =====
// Shared types, constants and codes for the LZ10 stream decompressor.
`default_nettype none

package lz10_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam int BYTE_W     = 8;
    localparam int OUT_LEN_W  = 24;
    localparam int ERR_W      = 2;
    localparam int DISP_W     = 13;
    localparam int LEN_W      = 5;
    localparam int BITS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [LEN_W-1:0]  MATCH_LEN_BIAS = 5'd3;
    localparam logic [BITS_W-1:0] FLAG_TOKENS    = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_EXTRA = 2'd1;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EARLY_END = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DISP      = 2'd2;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_MATCH = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        TOK_IGNORE   = 3'd0,
        TOK_FLAG     = 3'd1,
        TOK_LITERAL  = 3'd2,
        TOK_MATCH_HI = 3'd3,
        TOK_MATCH_LO = 3'd4
    } tok_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE       = 2'd0,
        ST_EVAL       = 2'd1,
        ST_COPY_START = 2'd2,
        ST_COPY       = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic take_in;
        logic apply_token;
        logic load_status;
        logic emit_literal;
        logic rd_issue;
        logic emit_copy;
    } lz10_cmd_t;

    typedef struct packed {
        logic      in_valid;
        tok_kind_t kind;
        logic      disp_bad;
        logic      out_free;
        logic      rem_zero;
    } lz10_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lz10_if.sv =====
// Stream, result and configuration channel interfaces.
`default_nettype none

interface lz10_in_if import lz10_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lz10_out_if import lz10_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              run_last;
    logic              done_res;
    logic [ERR_W-1:0]  error;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output done_res, output error, input ready);
    modport sink (input valid, input out_byte, input has_byte, input run_last,
                  input done_res, input error, output ready);
endinterface

interface lz10_cfg_if import lz10_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lz10_ctrl.sv =====
// Controller state machine sequencing token evaluation and match copies.
`default_nettype none

module lz10_ctrl import lz10_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  lz10_status_t status,
    output lz10_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.out_free)
                begin
                    if (status.kind == TOK_MATCH_LO && !status.disp_bad)
                    begin
                        state_next = ST_COPY_START;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_COPY_START:
            begin
                state_next = ST_COPY;
            end
            ST_COPY:
            begin
                if (status.out_free && status.rem_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.take_in  = status.in_valid;
            end
            ST_EVAL:
            begin
                if (status.out_free)
                begin
                    cmd.apply_token = 1'b1;
                    if (status.kind == TOK_LITERAL)
                    begin
                        cmd.emit_literal = 1'b1;
                    end
                    else if (!(status.kind == TOK_MATCH_LO && !status.disp_bad))
                    begin
                        cmd.load_status = 1'b1;
                    end
                end
            end
            ST_COPY_START:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_COPY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_copy = 1'b1;
                    cmd.rd_issue  = !status.rem_zero;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lz10_datapath.sv =====
// Datapath: token parser state, history ring, counters and result register.
`default_nettype none

module lz10_datapath import lz10_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lz10_in_if.sink      stream,
    lz10_out_if.source   result,
    lz10_cfg_if.sink     cfg,
    input  lz10_cmd_t    cmd,
    output lz10_status_t status
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int DW = AW + 1;
    localparam int CW = COUNT_WIDTH;
    localparam int WW = ((CW > OUT_LEN_W) ? CW : OUT_LEN_W) + 1;

    logic [BYTE_W-1:0] history_mem [WINDOW_SIZE];

    logic [OUT_LEN_W-1:0] out_length_reg, out_length_next;
    logic                 disp_extra_reg, disp_extra_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic                 full_reg, full_next;
    logic [CW-1:0]        produced_reg, produced_next;
    logic [BYTE_W-1:0]    flag_bits_reg, flag_bits_next;
    logic [BITS_W-1:0]    bits_left_reg, bits_left_next;
    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    first_reg, first_next;
    logic [ERR_W-1:0]     err_latch_reg, err_latch_next;
    logic                 step_done_reg, step_done_next;
    logic                 out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]    in_byte_reg, in_byte_next;
    logic                 in_last_reg, in_last_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [BYTE_W-1:0]    byp_data_reg;
    logic                 byp_hit_reg;
    logic                 rd_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 has_byte_reg, has_byte_next;
    logic                 run_last_reg, run_last_next;
    logic                 done_res_reg, done_res_next;
    logic [ERR_W-1:0]     error_reg, error_next;

    logic [WW-1:0]        prod_ext;
    logic [WW-1:0]        olen_ext;
    logic                 done_now;
    logic                 olen_fits;
    logic [CW-1:0]        lit_prod;
    logic                 lit_done;
    logic [LEN_W-1:0]     match_len;
    logic [DISP_W-1:0]    disp;
    logic                 disp_bad;
    logic [WW-1:0]        match_sum;
    logic [WW-1:0]        match_room;
    logic                 match_done;
    logic [LEN_W-1:0]     match_cnt;
    logic [DW-1:0]        wp_ext;
    logic [DW-1:0]        disp_ext;
    logic [DW-1:0]        src_wide;
    tok_kind_t            kind;
    logic                 step_done;
    logic [ERR_W-1:0]     step_err;
    logic [BITS_W-1:0]    bits_dec;
    logic [BYTE_W-1:0]    rd_data;
    logic                 mem_we;
    logic [BYTE_W-1:0]    mem_wd;
    logic [AW-1:0]        wp_inc;
    logic [AW-1:0]        src_inc;
    logic                 out_free;

    assign stream.ready = cmd.in_ready;
    assign cfg.ready    = 1'b1;

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.has_byte = has_byte_reg;
    assign result.run_last = run_last_reg;
    assign result.done_res = done_res_reg;
    assign result.error    = error_reg;

    assign out_free = !out_valid_reg || result.ready;

    assign status.in_valid = stream.valid;
    assign status.kind     = kind;
    assign status.disp_bad = disp_bad;
    assign status.out_free = out_free;
    assign status.rem_zero = (rem_reg == '0);

    assign prod_ext  = WW'(produced_reg);
    assign olen_ext  = WW'(out_length_reg);
    assign done_now  = (prod_ext >= olen_ext);
    assign olen_fits = (olen_ext < (WW'(1) << CW));

    assign lit_prod = produced_reg + CW'(1);
    assign lit_done = (WW'(lit_prod) >= olen_ext);

    assign match_len  = LEN_W'(first_reg[7:4]) + MATCH_LEN_BIAS;
    assign disp       = {first_reg[3:0], in_byte_reg} + DISP_W'(disp_extra_reg);
    assign disp_bad   = (WW'(disp) > prod_ext);
    assign match_sum  = prod_ext + WW'(match_len);
    assign match_room = olen_ext - prod_ext;
    assign match_done = olen_fits && (match_sum >= olen_ext);
    assign match_cnt  = match_done ? match_room[LEN_W-1:0] : match_len;

    assign wp_ext   = DW'(wp_reg);
    assign disp_ext = DW'(disp);
    assign src_wide = (wp_ext >= disp_ext) ? (wp_ext - disp_ext)
                                           : (wp_ext + DW'(WINDOW_SIZE) - disp_ext);

    assign wp_inc  = (wp_reg == AW'(WINDOW_SIZE - 1)) ? '0 : wp_reg + AW'(1);
    assign src_inc = (src_reg == AW'(WINDOW_SIZE - 1)) ? '0 : src_reg + AW'(1);

    assign rd_data = byp_hit_reg ? byp_data_reg : (rd_valid_reg ? rd_data_reg : '0);
    assign mem_we  = cmd.emit_literal || cmd.emit_copy;
    assign mem_wd  = cmd.emit_literal ? in_byte_reg : rd_data;

    assign bits_dec = (bits_left_reg != '0) ? bits_left_reg - BITS_W'(1) : '0;

    always_comb
    begin
        if (err_latch_reg != ERR_NONE || done_now)
        begin
            kind = TOK_IGNORE;
        end
        else
        begin
            case (phase_reg)
                PH_TOKEN: kind = flag_bits_reg[7] ? TOK_MATCH_HI : TOK_LITERAL;
                PH_MATCH: kind = TOK_MATCH_LO;
                default:  kind = TOK_FLAG;
            endcase
        end
    end

    always_comb
    begin
        step_done = done_now;
        step_err  = err_latch_reg;
        case (kind)
            TOK_FLAG, TOK_MATCH_HI:
            begin
                step_err = in_last_reg ? ERR_EARLY_END : ERR_NONE;
            end
            TOK_LITERAL:
            begin
                step_done = lit_done;
                step_err  = (in_last_reg && !lit_done) ? ERR_EARLY_END : ERR_NONE;
            end
            TOK_MATCH_LO:
            begin
                if (disp_bad)
                begin
                    step_err = ERR_DISP;
                end
                else
                begin
                    step_done = match_done;
                    step_err  = (in_last_reg && !match_done) ? ERR_EARLY_END : ERR_NONE;
                end
            end
            default:
            begin
                step_done = done_now;
                step_err  = err_latch_reg;
            end
        endcase
    end

    always_comb
    begin
        out_length_next = out_length_reg;
        disp_extra_next = disp_extra_reg;
        wp_next         = wp_reg;
        full_next       = full_reg;
        produced_next   = produced_reg;
        flag_bits_next  = flag_bits_reg;
        bits_left_next  = bits_left_reg;
        phase_next      = phase_reg;
        first_next      = first_reg;
        err_latch_next  = err_latch_reg;
        step_done_next  = step_done_reg;
        out_valid_next  = out_valid_reg;
        in_byte_next    = in_byte_reg;
        in_last_next    = in_last_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        out_byte_next   = out_byte_reg;
        has_byte_next   = has_byte_reg;
        run_last_next   = run_last_reg;
        done_res_next   = done_res_reg;
        error_next      = error_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_OUT_LENGTH: out_length_next = cfg.data[OUT_LEN_W-1:0];
                CFG_DISP_EXTRA: disp_extra_next = cfg.data[0];
                default:        out_length_next = out_length_reg;
            endcase
        end

        if (cmd.take_in)
        begin
            in_byte_next = stream.in_byte;
            in_last_next = stream.in_last;
        end

        if (cmd.apply_token)
        begin
            err_latch_next = step_err;
            step_done_next = step_done;
            case (kind)
                TOK_FLAG:
                begin
                    flag_bits_next = in_byte_reg;
                    bits_left_next = FLAG_TOKENS;
                    phase_next     = PH_TOKEN;
                end
                TOK_LITERAL:
                begin
                    flag_bits_next = {flag_bits_reg[BYTE_W-2:0], 1'b0};
                    bits_left_next = bits_dec;
                    phase_next     = (bits_dec != '0) ? PH_TOKEN : PH_FLAG;
                end
                TOK_MATCH_HI:
                begin
                    first_next = in_byte_reg;
                    phase_next = PH_MATCH;
                end
                TOK_MATCH_LO:
                begin
                    if (!disp_bad)
                    begin
                        flag_bits_next = {flag_bits_reg[BYTE_W-2:0], 1'b0};
                        bits_left_next = bits_dec;
                        phase_next     = (bits_dec != '0) ? PH_TOKEN : PH_FLAG;
                        src_next       = src_wide[AW-1:0];
                        rem_next       = match_cnt;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (cmd.rd_issue)
        begin
            src_next = src_inc;
            rem_next = rem_reg - LEN_W'(1);
        end

        if (mem_we)
        begin
            wp_next       = wp_inc;
            full_next     = full_reg || (wp_reg == AW'(WINDOW_SIZE - 1));
            produced_next = produced_reg + CW'(1);
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_status)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            has_byte_next  = 1'b0;
            run_last_next  = 1'b1;
            done_res_next  = step_done;
            error_next     = step_err;
        end
        else if (cmd.emit_literal)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = in_byte_reg;
            has_byte_next  = 1'b1;
            run_last_next  = 1'b1;
            done_res_next  = step_done;
            error_next     = step_err;
        end
        else if (cmd.emit_copy)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data;
            has_byte_next  = 1'b1;
            run_last_next  = (rem_reg == '0);
            done_res_next  = step_done_reg;
            error_next     = err_latch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_length_reg <= '0;
            disp_extra_reg <= 1'b1;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            produced_reg   <= '0;
            flag_bits_reg  <= '0;
            bits_left_reg  <= '0;
            phase_reg      <= PH_FLAG;
            first_reg      <= '0;
            err_latch_reg  <= ERR_NONE;
            step_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_length_reg <= out_length_next;
            disp_extra_reg <= disp_extra_next;
            wp_reg         <= wp_next;
            full_reg       <= full_next;
            produced_reg   <= produced_next;
            flag_bits_reg  <= flag_bits_next;
            bits_left_reg  <= bits_left_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            err_latch_reg  <= err_latch_next;
            step_done_reg  <= step_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        in_last_reg  <= in_last_next;
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        out_byte_reg <= out_byte_next;
        has_byte_reg <= has_byte_next;
        run_last_reg <= run_last_next;
        done_res_reg <= done_res_next;
        error_reg    <= error_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            history_mem[wp_reg] <= mem_wd;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg  <= history_mem[src_reg];
            byp_hit_reg  <= mem_we && (wp_reg == src_reg);
            byp_data_reg <= mem_wd;
            rd_valid_reg <= full_reg || (src_reg < wp_reg);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lz10_stream_decompressor_unit.sv =====
// Top level of the LZ10 stream decompressor: controller plus datapath.
// Flag byte, first match byte, literal or ignored item: one result once output is free.
// Second match byte: copied bytes follow at one byte per cycle from the
// single history read port while the result is taken; up to 18 bytes per match.
// Reset clears control state; history entries not yet written read as zero through
// write-pointer fill tracking, so no clearing pass is needed.
`default_nettype none

module lz10_stream_decompressor_unit import lz10_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lz10_in_if.sink    stream,
    lz10_out_if.source result,
    lz10_cfg_if.sink   cfg
);

    lz10_cmd_t    cmd;
    lz10_status_t status;

    lz10_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    lz10_datapath
    #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lz10_checker.sv =====
// Port-level assertions for the LZ10 stream decompressor and their bind.
`default_nettype none

module lz10_checker import lz10_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] out_byte,
    input wire logic              has_byte,
    input wire logic              run_last,
    input wire logic              done_res,
    input wire logic [ERR_W-1:0]  error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte)
            && $stable(run_last) && $stable(done_res) && $stable(error))
        else $error("stalled result changed");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_byte == '0 && run_last)
        else $error("status result carries data or is not last");

    a_disp_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error == ERR_DISP |-> !has_byte)
        else $error("byte emitted under displacement error");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

endmodule

bind lz10_stream_decompressor_unit lz10_checker u_lz10_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_byte  (result.out_byte),
    .has_byte  (result.has_byte),
    .run_last  (result.run_last),
    .done_res  (result.done_res),
    .error     (result.error)
);

`default_nettype wire
